FILE: src/nge_pkg.sv
// Shared types and constants for the next greater element engine.
package nge_pkg;

    localparam int DATA_W = 32;

    localparam logic [1:0] REQ_ELEM  = 2'd0;
    localparam logic [1:0] REQ_FLUSH = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic signed [DATA_W-1:0] NONE_GREATER = -32'sd1;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] next_greater;
        logic                     overflowed;
    } out_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] val;
    } pair_t;

endpackage

FILE: src/nge_pair_table.sv
// Pair table memory: one write port, one registered read port.
module nge_pair_table import nge_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  pair_t                    wr_pair,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output pair_t                    rd_pair
);

    pair_t mem [DEPTH];
    pair_t rd_pair_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_pair;
        end
        rd_pair_reg <= mem[rd_addr];
    end

    assign rd_pair = rd_pair_reg;

endmodule

FILE: src/next_greater_element_engine.sv
// Next greater element engine: monotonic stack, pair table and query search.
// Element word: one compare against the stack top per pop in ST_POP (plus one more
// unless the pops empty the stack); an element on an empty stack is pushed from ST_IDLE.
// End word: ST_FLUSH writes one pair per stacked entry flushed.
// Query word: ST_SCAN steps through the pair table entries in order (one compare a cycle).
// Result latency on a query is set by that scan; results wait in an output register.
// aresetn clears the counts, overflow flag and control; the memories are not cleared.
module next_greater_element_engine import nge_pkg::*; #(
    parameter int CAPACITY = 256
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_POP    = 3'd1;
    localparam logic [2:0] ST_FLUSH  = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [CW-1:0] stack_cnt_reg, stack_cnt_next;
    logic [CW-1:0] pair_cnt_reg, pair_cnt_next;
    logic [IW-1:0] scan_reg, scan_next;
    logic ovf_reg, ovf_next;
    logic hit_reg, hit_next;
    logic signed [DATA_W-1:0] hit_val_reg, hit_val_next;
    logic m_valid_reg, m_valid_next;
    out_word_t m_data_reg, m_data_next;

    logic signed [DATA_W-1:0] stack_mem [CAPACITY];
    logic signed [DATA_W-1:0] stack_rdata_reg;
    logic stack_we;
    logic [IW-1:0] stack_waddr, stack_raddr;
    logic signed [DATA_W-1:0] stack_wdata;

    logic pair_we;
    logic [IW-1:0] pair_raddr;
    pair_t pair_wdata, pair_rdata;

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        stack_rdata_reg <= stack_mem[stack_raddr];
    end

    nge_pair_table #(
        .DEPTH(CAPACITY)
    ) u_pair_table (
        .aclk    (aclk),
        .wr_en   (pair_we),
        .wr_addr (pair_cnt_reg[IW-1:0]),
        .wr_pair (pair_wdata),
        .rd_addr (pair_raddr),
        .rd_pair (pair_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next     = state_reg;
        value_next     = value_reg;
        stack_cnt_next = stack_cnt_reg;
        pair_cnt_next  = pair_cnt_reg;
        scan_next      = scan_reg;
        ovf_next       = ovf_reg;
        hit_next       = hit_reg;
        hit_val_next   = hit_val_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        stack_we    = 1'b0;
        stack_waddr = stack_cnt_reg[IW-1:0];
        stack_wdata = value_reg;
        stack_raddr = IW'(stack_cnt_reg - CW'(1));

        pair_we        = 1'b0;
        pair_wdata.key = stack_rdata_reg;
        pair_wdata.val = value_reg;
        pair_raddr     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    value_next = s_data.value;
                    scan_next  = '0;
                    case (s_data.req_type)
                        REQ_ELEM: begin
                            if (stack_cnt_reg == '0) begin
                                stack_we       = 1'b1;
                                stack_waddr    = '0;
                                stack_wdata    = s_data.value;
                                stack_cnt_next = CW'(1);
                            end else begin
                                state_next = ST_POP;
                            end
                        end
                        REQ_FLUSH: begin
                            if (stack_cnt_reg != '0) begin
                                state_next = ST_FLUSH;
                            end
                        end
                        REQ_QUERY: begin
                            if (pair_cnt_reg == '0) begin
                                hit_next   = 1'b0;
                                state_next = ST_RESULT;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_POP: begin
                // The registered read holds the current stack top.
                if (value_reg > stack_rdata_reg) begin
                    stack_cnt_next = stack_cnt_reg - CW'(1);
                    if (pair_cnt_reg < CAP_CNT) begin
                        pair_we       = 1'b1;
                        pair_cnt_next = pair_cnt_reg + CW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (stack_cnt_reg == CW'(1)) begin
                        stack_we       = 1'b1;
                        stack_waddr    = '0;
                        stack_cnt_next = CW'(1);
                        state_next     = ST_IDLE;
                    end else begin
                        stack_raddr = IW'(stack_cnt_reg - CW'(2));
                    end
                end else begin
                    if (stack_cnt_reg < CAP_CNT) begin
                        stack_we       = 1'b1;
                        stack_cnt_next = stack_cnt_reg + CW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                pair_wdata.val = NONE_GREATER;
                if (pair_cnt_reg < CAP_CNT) begin
                    pair_we       = 1'b1;
                    pair_cnt_next = pair_cnt_reg + CW'(1);
                end else begin
                    ovf_next = 1'b1;
                end
                stack_cnt_next = stack_cnt_reg - CW'(1);
                stack_raddr    = IW'(stack_cnt_reg - CW'(2));
                if (stack_cnt_reg == CW'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                pair_raddr = IW'(scan_reg + IW'(1));
                if (pair_rdata.key == value_reg) begin
                    hit_next     = 1'b1;
                    hit_val_next = pair_rdata.val;
                    state_next   = ST_RESULT;
                end else if ((CW'(scan_reg) + CW'(1)) == pair_cnt_reg) begin
                    hit_next   = 1'b0;
                    state_next = ST_RESULT;
                end else begin
                    scan_next = scan_reg + IW'(1);
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.found        = hit_reg;
                    m_data_next.next_greater = hit_reg ? hit_val_reg : '0;
                    m_data_next.overflowed   = ovf_reg;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            stack_cnt_reg <= '0;
            pair_cnt_reg  <= '0;
            ovf_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            stack_cnt_reg <= stack_cnt_next;
            pair_cnt_reg  <= pair_cnt_next;
            ovf_reg       <= ovf_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg   <= value_next;
        scan_reg    <= scan_next;
        hit_reg     <= hit_next;
        hit_val_reg <= hit_val_next;
        m_data_reg  <= m_data_next;
    end

endmodule

FILE: test/next_greater_element_engine_tb.sv
// Self-checking testbench for the next greater element engine.
module next_greater_element_engine_tb;
    import nge_pkg::*;

    localparam int CAPACITY = 256;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Tracks stack and pair table contents and the answers that queries must produce.
    class nge_tracker;
        logic signed [DATA_W-1:0] stack_vals [CAPACITY];
        int unsigned              stack_depth;
        logic signed [DATA_W-1:0] keys [CAPACITY];
        logic signed [DATA_W-1:0] vals [CAPACITY];
        int unsigned              pair_total;
        bit                       overflow;
        out_word_t                answers_due [$];
        int unsigned              faults;
        int unsigned              checked;

        function void record(logic signed [DATA_W-1:0] key, logic signed [DATA_W-1:0] val);
            if (pair_total >= CAPACITY) begin
                overflow = 1'b1;
            end else begin
                keys[pair_total] = key;
                vals[pair_total] = val;
                pair_total++;
            end
        endfunction

        function void note_word(in_word_t w);
            logic signed [DATA_W-1:0] v;
            out_word_t                ans;
            v = w.value;
            case (w.req_type)
                REQ_ELEM: begin
                    while (stack_depth > 0 && v > stack_vals[stack_depth-1]) begin
                        stack_depth--;
                        record(stack_vals[stack_depth], v);
                    end
                    if (stack_depth >= CAPACITY) begin
                        overflow = 1'b1;
                    end else begin
                        stack_vals[stack_depth] = v;
                        stack_depth++;
                    end
                end
                REQ_FLUSH: begin
                    while (stack_depth > 0) begin
                        stack_depth--;
                        record(stack_vals[stack_depth], NONE_GREATER);
                    end
                end
                REQ_QUERY: begin
                    ans.found        = 1'b0;
                    ans.next_greater = '0;
                    for (int unsigned i = 0; i < pair_total; i++) begin
                        if (keys[i] == v) begin
                            ans.found        = 1'b1;
                            ans.next_greater = vals[i];
                            break;
                        end
                    end
                    ans.overflowed = overflow;
                    answers_due.insert(answers_due.size(), ans);
                end
                default: ;
            endcase
        endfunction

        function void complain(string msg);
            faults++;
            if (faults <= 10)
                $display("%s", msg);
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            checked++;
            if (answers_due.size() == 0) begin
                complain($sformatf({"result %0d arrived with no query pending: ",
                                    "found=%0b next=%0d ovf=%0b"},
                                   checked, got.found, got.next_greater, got.overflowed));
                return;
            end
            want = answers_due.pop_front();
            if (got.found !== want.found || got.next_greater !== want.next_greater ||
                got.overflowed !== want.overflowed)
                complain($sformatf({"result %0d mismatch: expected found=%0b next=%0d ovf=%0b, ",
                                    "got found=%0b next=%0d ovf=%0b"}, checked,
                                   want.found, want.next_greater, want.overflowed,
                                   got.found, got.next_greater, got.overflowed));
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    nge_tracker  tracker = new();
    int unsigned sent;
    bit          calm;

    next_greater_element_engine #(.CAPACITY(CAPACITY)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #16_000_000;
        $display("tb: failure");
        $finish;
    end

    // Holds the word until it is taken; valid stays up across back-to-back words.
    task automatic send_word(input logic [1:0] kind, input logic signed [DATA_W-1:0] v);
        in_word_t    w;
        int unsigned gap;
        w.req_type = kind;
        w.value    = v;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        tracker.note_word(w);
        if (kind != REQ_UNUSED)
            sent++;
    endtask

    function automatic logic signed [DATA_W-1:0] draw_value(input bit narrow);
        if (narrow)
            return int'($urandom_range(0, 16)) - 8;
        return $urandom;
    endfunction

    // Mostly keys that are in the table, some that are still stacked, a few random ones.
    function automatic logic signed [DATA_W-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (tracker.pair_total > 0 && roll < 70)
            return tracker.keys[$urandom_range(0, tracker.pair_total - 1)];
        if (tracker.stack_depth > 0 && roll < 85)
            return tracker.stack_vals[$urandom_range(0, tracker.stack_depth - 1)];
        return draw_value(roll[0]);
    endfunction

    task automatic play_sequences(input int unsigned item_goal, input int unsigned pair_goal);
        int unsigned len;
        int unsigned roll;
        bit          narrow;
        while (sent < item_goal && tracker.pair_total < pair_goal) begin
            if ($urandom_range(0, 15) == 0)
                calm = !calm;
            len    = $urandom_range(1, 12);
            narrow = $urandom_range(0, 1);
            for (int unsigned k = 0; k < len; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 30)
                    send_word(REQ_QUERY, pick_key());
                else if (roll < 33)
                    send_word(REQ_UNUSED, draw_value(1'b0));
                send_word(REQ_ELEM, draw_value(narrow));
            end
            // Now and then the sequence is left open and the next one stacks on top.
            if ($urandom_range(0, 99) < 85)
                send_word(REQ_FLUSH, draw_value(1'b0));
            repeat ($urandom_range(0, 3)) send_word(REQ_QUERY, pick_key());
        end
    endtask

    initial begin : result_sink
        int unsigned stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 12);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            tracker.check_word(m_data);
        end
    end

    initial begin : stimulus
        logic signed [DATA_W-1:0] v;
        logic signed [DATA_W-1:0] last_pushed;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        sent = 0;
        calm = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, ignored type, extremes, equal values, duplicate keys.
        send_word(REQ_QUERY, 32'sd0);
        send_word(REQ_UNUSED, -32'sd1);
        send_word(REQ_ELEM, 32'sh8000_0000);
        send_word(REQ_ELEM, 32'sd5);
        send_word(REQ_ELEM, 32'sd3);
        send_word(REQ_ELEM, 32'sd3);
        send_word(REQ_ELEM, 32'sh7FFF_FFFF);
        send_word(REQ_ELEM, -32'sd1);
        send_word(REQ_FLUSH, 32'sd0);
        send_word(REQ_QUERY, 32'sh8000_0000);
        send_word(REQ_QUERY, 32'sd3);
        send_word(REQ_QUERY, 32'sd5);
        send_word(REQ_QUERY, 32'sh7FFF_FFFF);
        send_word(REQ_QUERY, -32'sd1);
        send_word(REQ_QUERY, 32'sd0);
        send_word(REQ_UNUSED, 32'sd0);
        send_word(REQ_ELEM, 32'sd7);
        send_word(REQ_QUERY, 32'sd7);
        send_word(REQ_FLUSH, -32'sd1);
        send_word(REQ_QUERY, 32'sd7);

        play_sequences(600, 150);

        // Let the engine run dry before the stack is pushed past its depth.
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.answers_due.size() != 0) @(posedge aclk);

        // A non-increasing run never pops, so the last words are dropped.
        v = 32'sd500000 + int'($urandom_range(0, 1000));
        last_pushed = v;
        for (int unsigned k = 0; k < CAPACITY + 2; k++) begin
            send_word(REQ_ELEM, v);
            if (k < CAPACITY)
                last_pushed = v;
            if ($urandom_range(0, 7) != 0)
                v = v - int'($urandom_range(1, 9));
            if (k % 32 == 0)
                send_word(REQ_QUERY, pick_key());
        end
        send_word(REQ_QUERY, last_pushed);
        send_word(REQ_ELEM, 32'sh7FFF_FFFF);
        send_word(REQ_QUERY, last_pushed);
        send_word(REQ_QUERY, v);
        repeat (6) send_word(REQ_QUERY, pick_key());
        send_word(REQ_FLUSH, 32'sd0);
        send_word(REQ_QUERY, 32'sh7FFF_FFFF);

        play_sequences(1200, CAPACITY + 1);

        s_valid <= 1'b0;
        while (tracker.answers_due.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        if (tracker.faults == 0 && tracker.answers_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
